// ===== hw/rtl/gdas_pkg.sv =====
// ----------------------------------------------------------------------------
// gdas_pkg
// Shared types, constants and the month-length table for the date adder.
// ----------------------------------------------------------------------------
package gdas_pkg;

    localparam int unsigned COUNT_BITS_DEF = 16;

    localparam int unsigned DAY_W   = 5;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned MLEN_W  = 5;
    localparam int unsigned YLEN_W  = 9;

    localparam logic [YEAR_W-1:0]  YEAR_MIN   = 14'd1;
    localparam logic [YEAR_W-1:0]  YEAR_MAX   = 14'd9999;
    localparam logic [MONTH_W-1:0] MONTH_JAN  = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC  = 4'd12;

    localparam logic [YLEN_W-1:0]  YLEN_LEAP  = 9'd366;
    localparam logic [YLEN_W-1:0]  YLEN_NORM  = 9'd365;
    localparam logic [MLEN_W-1:0]  FEB_LEAP   = 5'd29;

    // Divisibility by 25: y * inv(25) mod 2^14 is at most floor((2^14-1)/25)
    localparam logic [YEAR_W-1:0]  INV25      = 14'd7209;
    localparam logic [YEAR_W-1:0]  DIV25_MAX  = 14'd655;

    typedef struct packed {
        logic              leap;
        logic [MLEN_W-1:0] mlen;
        logic [YLEN_W-1:0] ylen;
    } t_cal_info;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CHECK = 6'b000010,
        S_DOY   = 6'b000100,
        S_YEAR  = 6'b001000,
        S_MONTH = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    // Non-leap month length; out-of-range codes read as 31
    function automatic logic [MLEN_W-1:0] month_len_norm(input logic [MONTH_W-1:0] m);
        logic [MLEN_W-1:0] len;
        begin
            unique case (m)
                4'd2:                     len = 5'd28;
                4'd4, 4'd6, 4'd9, 4'd11:  len = 5'd30;
                default:                  len = 5'd31;
            endcase
            return len;
        end
    endfunction

endpackage

// ===== hw/rtl/gdas_cal.sv =====
// ----------------------------------------------------------------------------
// gdas_cal
// Leap-year rule, month length and year length for one year and month.
// ----------------------------------------------------------------------------
module gdas_cal
    import gdas_pkg::*;
(
    input  logic [YEAR_W-1:0]  i_year,
    input  logic [MONTH_W-1:0] i_month,
    output t_cal_info          o_info
);

    logic [2*YEAR_W-1:0] prod;
    logic [YEAR_W-1:0]   prod_lo;
    logic                div4;
    logic                div16;
    logic                div25;
    logic                leap;

    assign prod    = {{YEAR_W{1'b0}}, i_year} * {{YEAR_W{1'b0}}, INV25};
    assign prod_lo = prod[YEAR_W-1:0];
    assign div25   = (prod_lo <= DIV25_MAX);
    assign div4    = (i_year[1:0] == 2'b00);
    assign div16   = (i_year[3:0] == 4'b0000);
    assign leap    = (div4 && !div25) || (div16 && div25);

    always_comb begin
        o_info.leap = leap;
        o_info.ylen = leap ? YLEN_LEAP : YLEN_NORM;
        if (i_month == MONTH_FEB && leap) begin
            o_info.mlen = FEB_LEAP;
        end else begin
            o_info.mlen = month_len_norm(i_month);
        end
    end

endmodule

// ===== hw/rtl/gregorian_date_add_sub_days.sv =====
// ----------------------------------------------------------------------------
// gregorian_date_add_sub_days: Gregorian date plus or minus a day count
// One item at a time, set by the shared add/compare loop, which walks the months
// up to the start month, then the years, then the months of the result year; a
// malformed start date is flagged in the check state instead. The next item can be
// taken in the cycle after the result leaves.
// o_stall is high from acceptance until the result is taken. Reset clears it.
// ----------------------------------------------------------------------------
module gregorian_date_add_sub_days
    import gdas_pkg::*;
#(
    parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_op,
    input  logic [DAY_W-1:0]      i_start_day,
    input  logic [MONTH_W-1:0]    i_start_month,
    input  logic [YEAR_W-1:0]     i_start_year,
    input  logic [COUNT_BITS-1:0] i_day_count,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [DAY_W-1:0]      o_result_day,
    output logic [MONTH_W-1:0]    o_result_month,
    output logic [YEAR_W-1:0]     o_result_year,
    output logic                  o_out_of_range
);

    localparam int unsigned REM_W = ((COUNT_BITS > YLEN_W) ? COUNT_BITS : YLEN_W) + 2;

    t_state                   r_state, n_state;
    logic                     r_op, n_op;
    logic [DAY_W-1:0]         r_day, n_day;
    logic [MONTH_W-1:0]       r_month, n_month;
    logic [YEAR_W-1:0]        r_syear, n_syear;
    logic [COUNT_BITS-1:0]    r_count, n_count;
    logic signed [REM_W-1:0]  r_rem, n_rem;
    logic [YEAR_W-1:0]        r_year, n_year;
    logic [MONTH_W-1:0]       r_mon, n_mon;
    logic [DAY_W-1:0]         r_res_day, n_res_day;
    logic [MONTH_W-1:0]       r_res_mon, n_res_mon;
    logic [YEAR_W-1:0]        r_res_year, n_res_year;
    logic                     r_flag, n_flag;

    logic [YEAR_W-1:0]        cal_year;
    logic [MONTH_W-1:0]       cal_month;
    t_cal_info                cal;
    logic signed [REM_W-1:0]  opnd;
    logic                     alu_sub;
    logic signed [REM_W-1:0]  sum;
    logic                     gt;
    logic                     apply_cnt;
    logic                     bad_date;

    assign cal_year  = (r_state == S_YEAR && r_op) ? (r_year - YEAR_MIN) : r_year;
    assign cal_month = (r_state == S_CHECK) ? r_month : r_mon;

    gdas_cal u_cal (
        .i_year  (cal_year),
        .i_month (cal_month),
        .o_info  (cal)
    );

    assign apply_cnt = (r_state == S_DOY) && (r_mon == r_month);

    // shared add/subtract and compare unit
    always_comb begin
        if (apply_cnt) begin
            opnd    = $signed({{(REM_W-COUNT_BITS){1'b0}}, r_count});
            alu_sub = r_op;
        end else if (r_state == S_YEAR) begin
            opnd    = $signed({{(REM_W-YLEN_W){1'b0}}, cal.ylen});
            alu_sub = !r_op;
        end else begin
            opnd    = $signed({{(REM_W-MLEN_W){1'b0}}, cal.mlen});
            alu_sub = (r_state == S_MONTH);
        end
    end

    assign sum = alu_sub ? (r_rem - opnd) : (r_rem + opnd);
    assign gt  = (r_rem > opnd);

    assign bad_date = (r_month < MONTH_JAN) || (r_month > MONTH_DEC)
                   || (r_syear < YEAR_MIN) || (r_syear > YEAR_MAX)
                   || (r_day == '0) || (r_day > cal.mlen);

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_day      = r_day;
        n_month    = r_month;
        n_syear    = r_syear;
        n_count    = r_count;
        n_rem      = r_rem;
        n_year     = r_year;
        n_mon      = r_mon;
        n_res_day  = r_res_day;
        n_res_mon  = r_res_mon;
        n_res_year = r_res_year;
        n_flag     = r_flag;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_op    = i_op;
                    n_day   = i_start_day;
                    n_month = i_start_month;
                    n_syear = i_start_year;
                    n_count = i_day_count;
                    n_rem   = $signed({{(REM_W-DAY_W){1'b0}}, i_start_day});
                    n_year  = i_start_year;
                    n_mon   = MONTH_JAN;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (bad_date) begin
                    n_res_day  = r_day;
                    n_res_mon  = r_month;
                    n_res_year = r_syear;
                    n_flag     = 1'b1;
                    n_state    = S_DONE;
                end else begin
                    n_state = S_DOY;
                end
            end
            S_DOY: begin
                n_rem = sum;
                if (apply_cnt) begin
                    n_state = S_YEAR;
                end else begin
                    n_mon = r_mon + MONTH_JAN;
                end
            end
            S_YEAR: begin
                if (!r_op) begin
                    if (gt) begin
                        if (r_year >= YEAR_MAX) begin
                            n_res_day  = r_day;
                            n_res_mon  = r_month;
                            n_res_year = r_syear;
                            n_flag     = 1'b1;
                            n_state    = S_DONE;
                        end else begin
                            n_rem  = sum;
                            n_year = r_year + YEAR_MIN;
                        end
                    end else begin
                        n_mon   = MONTH_JAN;
                        n_state = S_MONTH;
                    end
                end else begin
                    if (r_rem[REM_W-1] || r_rem == '0) begin
                        if (r_year <= YEAR_MIN) begin
                            n_res_day  = r_day;
                            n_res_mon  = r_month;
                            n_res_year = r_syear;
                            n_flag     = 1'b1;
                            n_state    = S_DONE;
                        end else begin
                            n_rem  = sum;
                            n_year = cal_year;
                        end
                    end else begin
                        n_mon   = MONTH_JAN;
                        n_state = S_MONTH;
                    end
                end
            end
            S_MONTH: begin
                if (r_mon < MONTH_DEC && gt) begin
                    n_rem = sum;
                    n_mon = r_mon + MONTH_JAN;
                end else begin
                    n_res_day  = r_rem[DAY_W-1:0];
                    n_res_mon  = r_mon;
                    n_res_year = r_year;
                    n_flag     = 1'b0;
                    n_state    = S_DONE;
                end
            end
            S_DONE: begin
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_day      <= n_day;
        r_month    <= n_month;
        r_syear    <= n_syear;
        r_count    <= n_count;
        r_rem      <= n_rem;
        r_year     <= n_year;
        r_mon      <= n_mon;
        r_res_day  <= n_res_day;
        r_res_mon  <= n_res_mon;
        r_res_year <= n_res_year;
        r_flag     <= n_flag;
    end

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = (r_state == S_DONE);
    assign o_result_day   = r_res_day;
    assign o_result_month = r_res_mon;
    assign o_result_year  = r_res_year;
    assign o_out_of_range = r_flag;

    a_busy_while_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input not stalled while a result is pending");

    a_good_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_out_of_range) |->
            (o_result_day != '0 && o_result_month >= MONTH_JAN
             && o_result_month <= MONTH_DEC && o_result_year >= YEAR_MIN
             && o_result_year <= YEAR_MAX))
        else $error("unflagged result is not a valid date");

    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result appeared without an item in progress");

endmodule

// ===== sim/date_ops_pkg.sv =====
// ----------------------------------------------------------------------------
// date_ops_pkg
// Operation codes, the result record and calendar helpers shared by the
// date adder testbench and its checker.
// ----------------------------------------------------------------------------
package date_ops_pkg;
    import gdas_pkg::*;

    typedef enum logic {
        OP_ADD = 1'b0,
        OP_SUB = 1'b1
    } t_date_op;

    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic               out_of_range;
    } t_shifted_date;

    function automatic bit leap_year(int y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    // any month code outside 1..12 reads as 31 days
    function automatic int days_in_month(int m, int y);
        case (m)
            2: begin
                return leap_year(y) ? 29 : 28;
            end
            4, 6, 9, 11: begin
                return 30;
            end
            default: begin
                return 31;
            end
        endcase
    endfunction

    function automatic int days_in_year(int y);
        return leap_year(y) ? 366 : 365;
    endfunction

endpackage

// ===== sim/date_shift_checker.sv =====
// ----------------------------------------------------------------------------
// date_shift_checker
// Watches both channels of the date adder, computes the shifted date for
// every accepted item and compares each accepted result with the oldest one.
// ----------------------------------------------------------------------------
module date_shift_checker
    import gdas_pkg::*;
    import date_ops_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_item_valid,
    input  logic                      i_item_stall,
    input  logic                      i_op,
    input  logic [DAY_W-1:0]          i_start_day,
    input  logic [MONTH_W-1:0]        i_start_month,
    input  logic [YEAR_W-1:0]         i_start_year,
    input  logic [COUNT_BITS_DEF-1:0] i_day_count,
    input  logic                      i_result_valid,
    input  logic                      i_result_stall,
    input  logic [DAY_W-1:0]          i_result_day,
    input  logic [MONTH_W-1:0]        i_result_month,
    input  logic [YEAR_W-1:0]         i_result_year,
    input  logic                      i_out_of_range,
    output int                        o_mismatch_count,
    output int                        o_dates_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    t_shifted_date pending_dates[$];
    int            mismatch_count = 0;
    int            dates_pending  = 0;

    assign o_mismatch_count = mismatch_count;
    assign o_dates_pending  = dates_pending;

    function automatic t_shifted_date shift_date(
        t_date_op                  op,
        logic [DAY_W-1:0]          d,
        logic [MONTH_W-1:0]        m,
        logic [YEAR_W-1:0]         y,
        logic [COUNT_BITS_DEF-1:0] n
    );
        t_shifted_date res;
        int            doy;
        int            yr;
        int            mo;
        bit            over;
        res.day          = d;
        res.month        = m;
        res.year         = y;
        res.out_of_range = 1'b0;
        if (m < MONTH_JAN || m > MONTH_DEC || y < YEAR_MIN || y > YEAR_MAX ||
            d == 0 || d > days_in_month(m, y)) begin
            res.out_of_range = 1'b1;
            return res;
        end
        doy  = d;
        yr   = y;
        over = 1'b0;
        for (mo = 1; mo < m; mo++) begin
            doy += days_in_month(mo, y);
        end
        if (op == OP_ADD) begin
            doy += n;
            while (doy > days_in_year(yr)) begin
                doy -= days_in_year(yr);
                if (yr >= YEAR_MAX) begin
                    over = 1'b1;
                    break;
                end
                yr++;
            end
        end else begin
            doy -= n;
            while (doy < 1) begin
                if (yr <= YEAR_MIN) begin
                    over = 1'b1;
                    break;
                end
                yr--;
                doy += days_in_year(yr);
            end
        end
        if (over) begin
            res.out_of_range = 1'b1;
        end else begin
            mo = 1;
            while (mo < 12 && doy > days_in_month(mo, yr)) begin
                doy -= days_in_month(mo, yr);
                mo++;
            end
            res.day   = DAY_W'(doy);
            res.month = MONTH_W'(mo);
            res.year  = YEAR_W'(yr);
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_shifted_date want;
        if (i_rst_n) begin
            if (i_result_valid && !i_result_stall) begin
                if (pending_dates.size() == 0) begin
                    $error("result %0d-%0d-%0d flag %0d with no item waiting",
                           i_result_year, i_result_month, i_result_day, i_out_of_range);
                    mismatch_count++;
                end else begin
                    want = pending_dates.pop_front();
                    if (i_result_day !== want.day) begin
                        $error("result_day: expected %0d, got %0d", want.day, i_result_day);
                        mismatch_count++;
                    end
                    if (i_result_month !== want.month) begin
                        $error("result_month: expected %0d, got %0d",
                               want.month, i_result_month);
                        mismatch_count++;
                    end
                    if (i_result_year !== want.year) begin
                        $error("result_year: expected %0d, got %0d",
                               want.year, i_result_year);
                        mismatch_count++;
                    end
                    if (i_out_of_range !== want.out_of_range) begin
                        $error("out_of_range: expected %0d, got %0d",
                               want.out_of_range, i_out_of_range);
                        mismatch_count++;
                    end
                end
            end
            if (i_item_valid && !i_item_stall) begin
                pending_dates.push_back(shift_date(t_date_op'(i_op), i_start_day,
                                                   i_start_month, i_start_year, i_day_count));
            end
            dates_pending = pending_dates.size();
        end
    end

endmodule

// ===== sim/gregorian_date_add_sub_days_test.sv =====
// ----------------------------------------------------------------------------
// gregorian_date_add_sub_days_test
// Drives directed and random dates, counts and operations into the date
// adder with random gaps and output stalls; a checker beside the block
// predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module gregorian_date_add_sub_days_test
    import gdas_pkg::*;
    import date_ops_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 650;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 250;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_stall;
    logic                      i_op;
    logic [DAY_W-1:0]          i_start_day;
    logic [MONTH_W-1:0]        i_start_month;
    logic [YEAR_W-1:0]         i_start_year;
    logic [COUNT_BITS_DEF-1:0] i_day_count;
    logic                      o_valid;
    logic                      i_stall;
    logic [DAY_W-1:0]          o_result_day;
    logic [MONTH_W-1:0]        o_result_month;
    logic [YEAR_W-1:0]         o_result_year;
    logic                      o_out_of_range;

    int mismatch_count;
    int dates_pending;
    int stall_left = 0;
    int idle_cycles = 0;
    bit calm = 1'b0;

    gregorian_date_add_sub_days u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_op           (i_op),
        .i_start_day    (i_start_day),
        .i_start_month  (i_start_month),
        .i_start_year   (i_start_year),
        .i_day_count    (i_day_count),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_result_day   (o_result_day),
        .o_result_month (o_result_month),
        .o_result_year  (o_result_year),
        .o_out_of_range (o_out_of_range)
    );

    date_shift_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_item_valid     (i_valid),
        .i_item_stall     (o_stall),
        .i_op             (i_op),
        .i_start_day      (i_start_day),
        .i_start_month    (i_start_month),
        .i_start_year     (i_start_year),
        .i_day_count      (i_day_count),
        .i_result_valid   (o_valid),
        .i_result_stall   (i_stall),
        .i_result_day     (o_result_day),
        .i_result_month   (o_result_month),
        .i_result_year    (o_result_year),
        .i_out_of_range   (o_out_of_range),
        .o_mismatch_count (mismatch_count),
        .o_dates_pending  (dates_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // result side backpressure in random bursts
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_stall    <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            i_stall    <= 1'b1;
            stall_left <= $urandom_range(0, 3);
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic send_date(input t_date_op op, input int d, input int m, input int y,
                             input int n);
        bit taken;
        if (!calm && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_op          <= op;
        i_start_day   <= DAY_W'(d);
        i_start_month <= MONTH_W'(m);
        i_start_year  <= YEAR_W'(y);
        i_day_count   <= COUNT_BITS_DEF'(n);
        do begin
            taken = !o_stall;
            @(negedge i_clk);
        end while (!taken);
    endtask

    task automatic send_random_date();
        int       pick;
        int       d;
        int       m;
        int       y;
        int       n;
        t_date_op op;
        pick = $urandom_range(0, 99);
        op   = t_date_op'($urandom_range(0, 1));
        if (pick < 8) begin
            // raw fields, mostly malformed dates
            d = $urandom_range(0, 31);
            m = $urandom_range(0, 15);
            y = $urandom_range(0, 16383);
            n = $urandom_range(0, 65535);
        end else begin
            m = $urandom_range(1, 12);
            case ($urandom_range(0, 9))
                0, 1: y = $urandom_range(1, 300);
                2, 3: y = $urandom_range(9700, 9999);
                4:    y = 100 * $urandom_range(1, 99);
                default: y = $urandom_range(1, 9999);
            endcase
            if ($urandom_range(0, 7) == 0) begin
                d = days_in_month(m, y);
            end else begin
                d = $urandom_range(1, days_in_month(m, y));
            end
            case ($urandom_range(0, 19))
                0:          n = 0;
                1:          n = 65535;
                2, 3, 4, 5: n = $urandom_range(0, 400);
                6, 7, 8:    n = $urandom_range(0, 3000);
                default:    n = $urandom_range(0, 65535);
            endcase
        end
        send_date(op, d, m, y, n);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_op          = OP_ADD;
        i_start_day   = '0;
        i_start_month = '0;
        i_start_year  = '0;
        i_day_count   = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_date(OP_ADD, 15, 6, 2021, 0);
        send_date(OP_SUB, 15, 6, 2021, 0);
        send_date(OP_ADD, 1, 1, 1, 65535);
        send_date(OP_SUB, 31, 12, 9999, 65535);
        send_date(OP_ADD, 31, 12, 9999, 1);
        send_date(OP_SUB, 1, 1, 1, 1);
        send_date(OP_ADD, 1, 1, 9900, 65535);
        send_date(OP_SUB, 31, 12, 100, 65535);
        send_date(OP_ADD, 28, 2, 2024, 1);
        send_date(OP_ADD, 28, 2, 1900, 1);
        send_date(OP_ADD, 28, 2, 2000, 1);
        send_date(OP_SUB, 1, 3, 2000, 1);
        send_date(OP_SUB, 1, 3, 1900, 1);
        send_date(OP_ADD, 31, 12, 2023, 1);
        send_date(OP_SUB, 1, 1, 2024, 1);
        // malformed start dates echo back with the flag
        send_date(OP_ADD, 10, 0, 2020, 5);
        send_date(OP_ADD, 10, 13, 2020, 5);
        send_date(OP_SUB, 31, 15, 16383, 65535);
        send_date(OP_ADD, 10, 5, 0, 5);
        send_date(OP_SUB, 10, 5, 16383, 5);
        send_date(OP_ADD, 0, 5, 2020, 5);
        send_date(OP_ADD, 31, 4, 2020, 5);
        send_date(OP_ADD, 29, 2, 2023, 5);
        send_date(OP_SUB, 30, 2, 2024, 5);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            calm = (i >= 300 && i < 360) || (i >= RANDOM_ITEMS - 80);
            send_random_date();
        end
        i_valid <= 1'b0;

        while (dates_pending != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatch_count == 0 && dates_pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
